// ===== rtl/cplr_pkg.sv =====
package cplr_pkg;

  // Default level format: signed Q8.7 dB in 16 bits.
  localparam int LEVEL_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 7;

  // Loop gain is an unsigned fraction in units of 1/256.
  localparam int GAIN_WIDTH = 8;
  localparam int GAIN_SHIFT = 8;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = GAIN_WIDTH'(51);

  // Reset values of the tolerance and limit registers, and the abort result level, in tenths of a dB or whole dB.
  localparam int CAL_TOL_DB_X10  = 2;
  localparam int TEST_TOL_DB_X10 = 3;
  localparam int RX_LIMIT_DB     = 120;
  localparam int GEN_LIMIT_DB    = 126;
  localparam int ABORT_LEVEL_DB  = -100;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_KIND     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CAL_TOL  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEST_TOL = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RX_LIM   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GEN_LIM  = 3'd5;

  // Regulation kinds.
  localparam logic KIND_CALIBRATE = 1'b0;
  localparam logic KIND_TEST      = 1'b1;

  // Request modes.
  localparam logic MODE_BEGIN   = 1'b0;
  localparam logic MODE_MEASURE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_APPLY   = 2'd0,
    ST_SETTLED = 2'd1,
    ST_ABORTED = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

endpackage

// ===== rtl/clamped_proportional_level_regulator.sv =====
// Clamped proportional level regulator.
//
// Input channel (in_valid/in_ready): a begin request (in_mode 0) loads the
// start drive, target and ceiling; a measurement request (in_mode 1) carries
// the receiver reading. Each request yields exactly one result on the output
// channel (out_valid/out_ready): the drive to apply, or a settled, aborted or
// ignored status.
// Configuration: cfg_we writes cfg_data into the register cfg_index; write
// only while no request is in flight.
// Flow: a request is accepted into the input register, and its result is
// loaded into the result register when the request moves on, which a stalled
// result can hold back. Throughput: one request per cycle unless the result
// stalls; the whole update (one 17x9 multiply, an add and a saturate/clamp)
// runs in a single combinational pass between the two registers.
// Reset: the pipeline empties, the drive, target and ceiling return to zero,
// the block is idle, and the registers take their default values.
// Stall: while out_ready is low the result holds; the input register still
// takes one more request, after which in_ready drops until the result leaves.
module clamped_proportional_level_regulator #(
  parameter int LEVEL_WIDTH   = cplr_pkg::LEVEL_WIDTH_DEF,
  parameter int FRACTION_BITS = cplr_pkg::FRACTION_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [LEVEL_WIDTH-1:0]        in_start_level,
  input  logic signed [LEVEL_WIDTH-1:0]        in_target_level,
  input  logic signed [LEVEL_WIDTH-1:0]        in_ceiling_level,
  input  logic signed [LEVEL_WIDTH-1:0]        in_measured_level,
  input  logic                                 in_stop_request,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic signed [LEVEL_WIDTH-1:0]        out_drive_out,
  output logic signed [LEVEL_WIDTH-1:0]        out_result_level,
  output logic                                 out_was_clamped,
  // Configuration port.
  input  logic                                 cfg_we,
  input  logic [cplr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [LEVEL_WIDTH-1:0]               cfg_data
);

  localparam int LW = LEVEL_WIDTH;
  localparam int TW = LEVEL_WIDTH - 1;
  localparam int GW = cplr_pkg::GAIN_WIDTH;
  localparam int PW = LW + GW + 2;

  // Level constants in the chosen fixed-point format, saturated to range.
  localparam longint OneDb  = longint'(1) << FRACTION_BITS;
  localparam longint LvlMax = (longint'(1) << (LW - 1)) - 1;
  localparam longint LvlMin = -LvlMax - 1;
  localparam longint RxRaw  = cplr_pkg::RX_LIMIT_DB * OneDb;
  localparam longint GenRaw = cplr_pkg::GEN_LIMIT_DB * OneDb;
  localparam longint AbRaw  = cplr_pkg::ABORT_LEVEL_DB * OneDb;
  localparam logic [TW-1:0] CalTolDef  = TW'((cplr_pkg::CAL_TOL_DB_X10 * OneDb + 5) / 10);
  localparam logic [TW-1:0] TestTolDef = TW'((cplr_pkg::TEST_TOL_DB_X10 * OneDb + 5) / 10);
  localparam logic [LW-1:0] RxLimDef   = LW'((RxRaw > LvlMax) ? LvlMax : RxRaw);
  localparam logic [LW-1:0] GenLimDef  = LW'((GenRaw > LvlMax) ? LvlMax : GenRaw);
  localparam logic [LW-1:0] AbortLevel = LW'((AbRaw < LvlMin) ? LvlMin : AbRaw);
  localparam logic signed [PW-1:0] RoundHalf = PW'(longint'(1) << (cplr_pkg::GAIN_SHIFT - 1));
  localparam logic signed [LW+2:0] SatMax = (LW+3)'(LvlMax);
  localparam logic signed [LW+2:0] SatMin = (LW+3)'(LvlMin);

  // Configuration registers.
  logic                        kind_r;
  logic [GW-1:0]               gain_r;
  logic [TW-1:0]               cal_tol_r;
  logic [TW-1:0]               test_tol_r;
  logic signed [LW-1:0]        rx_lim_r;
  logic signed [LW-1:0]        gen_lim_r;

  // Input register.
  logic                        s1_valid_r;
  logic                        s1_mode_r;
  logic signed [LW-1:0]        s1_start_r;
  logic signed [LW-1:0]        s1_target_r;
  logic signed [LW-1:0]        s1_ceiling_r;
  logic signed [LW-1:0]        s1_meas_r;
  logic                        s1_stop_r;

  // Regulator state.
  logic signed [LW-1:0]        drive_r, drive_nxt;
  logic signed [LW-1:0]        target_r, target_nxt;
  logic signed [LW-1:0]        ceiling_r, ceiling_nxt;
  logic                        clamp_r, clamp_nxt;
  logic                        regulating_r, regulating_nxt;

  // Result register.
  logic                        out_valid_r;
  cplr_pkg::status_t           status_r, status_nxt;
  logic signed [LW-1:0]        res_drive_r, res_drive_nxt;
  logic signed [LW-1:0]        res_level_r, res_level_nxt;
  logic                        res_clamp_r, res_clamp_nxt;

  logic                        advance;
  logic                        test_kind;
  logic signed [LW:0]          err;
  logic [LW:0]                 err_mag;
  logic [TW-1:0]               tol;
  logic                        within_tol;
  logic signed [PW-1:0]        prod;
  logic signed [PW-1:0]        prod_rnd;
  logic signed [LW+1:0]        delta;
  logic signed [LW+2:0]        drive_sum;
  logic signed [LW-1:0]        drive_upd;
  logic                        prod_pos;
  logic                        abort;

  // Handshake: the input register moves on when the result register is free.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;

  assign out_status       = status_r;
  assign out_drive_out    = res_drive_r;
  assign out_result_level = res_level_r;
  assign out_was_clamped  = res_clamp_r;

  assign test_kind = (kind_r == cplr_pkg::KIND_TEST);

  // Error, its magnitude and the tolerance check.
  assign err        = {target_r[LW-1], target_r} - {s1_meas_r[LW-1], s1_meas_r};
  assign err_mag    = err[LW] ? (LW+1)'(0) - err : err;
  assign tol        = test_kind ? test_tol_r : cal_tol_r;
  assign within_tol = (err_mag <= {2'b00, tol});

  // Proportional correction, rounded half up, then added with saturation.
  assign prod      = PW'(err) * PW'($signed({1'b0, gain_r}));
  assign prod_rnd  = prod + RoundHalf;
  assign delta     = (LW+2)'(prod_rnd >>> cplr_pkg::GAIN_SHIFT);
  assign drive_sum = (LW+3)'(drive_r) + (LW+3)'(delta);
  assign drive_upd = (drive_sum > SatMax) ? LW'(SatMax) :
                     (drive_sum < SatMin) ? LW'(SatMin) : LW'(drive_sum);
  assign prod_pos  = (gain_r != '0) && !err[LW] && (err != '0);

  // One regulation step for the request in the input register.
  always_comb begin
    drive_nxt      = drive_r;
    target_nxt     = target_r;
    ceiling_nxt    = ceiling_r;
    clamp_nxt      = clamp_r;
    regulating_nxt = regulating_r;
    status_nxt     = cplr_pkg::ST_APPLY;
    res_drive_nxt  = drive_r;
    res_level_nxt  = '0;
    res_clamp_nxt  = 1'b0;
    abort          = 1'b0;

    if (s1_mode_r == cplr_pkg::MODE_BEGIN) begin
      // Begin: load the new point and check the start drive.
      target_nxt     = s1_target_r;
      ceiling_nxt    = s1_ceiling_r;
      regulating_nxt = 1'b1;
      clamp_nxt      = 1'b0;
      drive_nxt      = s1_start_r;
      if (s1_stop_r) begin
        abort = 1'b1;
      end else if (test_kind) begin
        if (s1_start_r >= s1_ceiling_r) begin
          drive_nxt = s1_ceiling_r;
          clamp_nxt = 1'b1;
        end
      end else if (s1_start_r > gen_lim_r) begin
        abort = 1'b1;
      end
      res_drive_nxt = drive_nxt;
      res_clamp_nxt = clamp_nxt;
    end else if (!regulating_r) begin
      // A measurement with no regulation running is answered and dropped.
      status_nxt = cplr_pkg::ST_IGNORED;
    end else if ((s1_meas_r > rx_lim_r) || s1_stop_r) begin
      abort = 1'b1;
    end else if (within_tol || (test_kind && clamp_r && prod_pos)) begin
      // Settled, either within tolerance or pinned at the ceiling.
      status_nxt     = cplr_pkg::ST_SETTLED;
      regulating_nxt = 1'b0;
      res_level_nxt  = s1_meas_r;
      res_clamp_nxt  = clamp_r;
    end else begin
      // Proportional step, then the kind's limit.
      drive_nxt = drive_upd;
      if (test_kind) begin
        if (drive_upd >= ceiling_r) begin
          drive_nxt = ceiling_r;
          clamp_nxt = 1'b1;
        end else begin
          clamp_nxt = 1'b0;
        end
      end else begin
        clamp_nxt = 1'b0;
        if (drive_upd > gen_lim_r) begin
          abort = 1'b1;
        end
      end
      res_drive_nxt = drive_nxt;
      res_clamp_nxt = clamp_nxt;
    end

    // Abort forces the drive to zero and ends the regulation.
    if (abort) begin
      drive_nxt      = '0;
      clamp_nxt      = 1'b0;
      regulating_nxt = 1'b0;
      status_nxt     = cplr_pkg::ST_ABORTED;
      res_drive_nxt  = '0;
      res_level_nxt  = AbortLevel;
      res_clamp_nxt  = 1'b0;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= cplr_pkg::KIND_TEST;
      gain_r     <= cplr_pkg::GAIN_RESET;
      cal_tol_r  <= CalTolDef;
      test_tol_r <= TestTolDef;
      rx_lim_r   <= RxLimDef;
      gen_lim_r  <= GenLimDef;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cplr_pkg::CFG_KIND:     kind_r     <= cfg_data[0];
        cplr_pkg::CFG_GAIN:     gain_r     <= cfg_data[GW-1:0];
        cplr_pkg::CFG_CAL_TOL:  cal_tol_r  <= cfg_data[TW-1:0];
        cplr_pkg::CFG_TEST_TOL: test_tol_r <= cfg_data[TW-1:0];
        cplr_pkg::CFG_RX_LIM:   rx_lim_r   <= cfg_data;
        cplr_pkg::CFG_GEN_LIM:  gen_lim_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode_r    <= in_mode;
      s1_start_r   <= in_start_level;
      s1_target_r  <= in_target_level;
      s1_ceiling_r <= in_ceiling_level;
      s1_meas_r    <= in_measured_level;
      s1_stop_r    <= in_stop_request;
    end
  end

  // Regulator state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r      <= '0;
      target_r     <= '0;
      ceiling_r    <= '0;
      clamp_r      <= 1'b0;
      regulating_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) begin
        drive_r      <= drive_nxt;
        target_r     <= target_nxt;
        ceiling_r    <= ceiling_nxt;
        clamp_r      <= clamp_nxt;
        regulating_r <= regulating_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      status_r    <= status_nxt;
      res_drive_r <= res_drive_nxt;
      res_level_r <= res_level_nxt;
      res_clamp_r <= res_clamp_nxt;
    end
  end

endmodule

// ===== rtl/cplr_checker.sv =====
module cplr_checker #(
  parameter int LEVEL_WIDTH = cplr_pkg::LEVEL_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [1:0]             out_status,
  input logic [LEVEL_WIDTH-1:0] out_drive_out,
  input logic [LEVEL_WIDTH-1:0] out_result_level,
  input logic                   out_was_clamped
);

  // A stalled result holds its status and drive.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_drive_out))
    else $error("result changed while stalled");

  // An abort always shows a zero drive and no clamp.
  a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cplr_pkg::ST_ABORTED) |->
      (out_drive_out == '0) && !out_was_clamped)
    else $error("abort result with nonzero drive or clamp");

  // An ignored measurement reports no level and no clamp.
  a_ignore_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cplr_pkg::ST_IGNORED) |->
      (out_result_level == '0) && !out_was_clamped)
    else $error("ignored result carries level or clamp");

  // A drive update carries no final level.
  a_apply_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == cplr_pkg::ST_APPLY) |-> (out_result_level == '0))
    else $error("drive update carries a result level");

  // Reset leaves an empty pipeline ready for a request.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind clamped_proportional_level_regulator cplr_checker #(
  .LEVEL_WIDTH(LEVEL_WIDTH)
) u_cplr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_status       (out_status),
  .out_drive_out    (out_drive_out),
  .out_result_level (out_result_level),
  .out_was_clamped  (out_was_clamped)
);
